@@ hdl/dfe_pkg.sv @@
// Shared types, codes and the CRC-16 byte update for the DLE frame encoder.
// No dependencies; every module imports this package.
package dfe_pkg;

    // Line control codes
    localparam logic [7:0] DLE_CODE = 8'h10;
    localparam logic [7:0] STX_CODE = 8'h02;
    localparam logic [7:0] ETX_CODE = 8'h03;

    // CRC-16 polynomial, MSB-first, init zero, no final xor
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Fixed byte slots of one result packet, in line order
    localparam int NSLOT  = 12;
    localparam int SLOT_W = 4;
    localparam logic [SLOT_W-1:0] SLOT_DLE0 = 4'd0;
    localparam logic [SLOT_W-1:0] SLOT_STX  = 4'd1;
    localparam logic [SLOT_W-1:0] SLOT_HDR  = 4'd2;
    localparam logic [SLOT_W-1:0] SLOT_HDR2 = 4'd3;
    localparam logic [SLOT_W-1:0] SLOT_DAT  = 4'd4;
    localparam logic [SLOT_W-1:0] SLOT_DAT2 = 4'd5;
    localparam logic [SLOT_W-1:0] SLOT_CHI  = 4'd6;
    localparam logic [SLOT_W-1:0] SLOT_CHI2 = 4'd7;
    localparam logic [SLOT_W-1:0] SLOT_CLO  = 4'd8;
    localparam logic [SLOT_W-1:0] SLOT_CLO2 = 4'd9;
    localparam logic [SLOT_W-1:0] SLOT_DLE1 = 4'd10;
    localparam logic [SLOT_W-1:0] SLOT_ETX  = 4'd11;

    // One input transaction
    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
        logic [2:0] sequence_req;
        logic [4:0] piggyback;
    } t_in_item;

    // Registered input stage handed to the frame builder
    typedef struct packed {
        logic       valid;
        t_in_item   item;
        logic [7:0] hdr;
        logic [15:0] hdr_crc;
    } t_stage;

    // One result packet: slot bytes plus a mask of slots to send
    typedef struct packed {
        logic [NSLOT-1:0][7:0] bytes;
        logic [NSLOT-1:0]      mask;
    } t_pkt;

    // CRC-16 update over one byte, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ hdl/dfe_in_if.sv @@
// Input channel of the DLE frame encoder: valid/ready plus item fields.
// No dependencies.
interface dfe_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
    logic [2:0] sequence_req;
    logic [4:0] piggyback;

    modport source (output valid, func, data_byte, first_byte, last_byte,
                    sequence_req, piggyback, input ready);
    modport sink   (input valid, func, data_byte, first_byte, last_byte,
                    sequence_req, piggyback, output ready);
endinterface

@@ hdl/dfe_out_if.sv @@
// Output channel of the DLE frame encoder: valid/ready, one line byte and two flags.
// No dependencies.
interface dfe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_done;

    modport source (output valid, out_byte, run_last, frame_done, input ready);
    modport sink   (input valid, out_byte, run_last, frame_done, output ready);
endinterface

@@ hdl/dfe_in_stage.sv @@
// Input register of the frame encoder; also forms the header and its CRC.
// Depends on dfe_pkg and dfe_in_if.
module dfe_in_stage
    import dfe_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    dfe_in_if.sink i_item,
    input  logic   i_advance,
    output t_stage o_stage
);

    logic        r_valid;
    t_in_item    r_item;
    logic [7:0]  r_hdr;
    logic [15:0] r_hdr_crc;
    logic [7:0]  n_hdr;
    logic        take;

    assign i_item.ready = !r_valid || i_advance;
    assign take         = i_item.valid && i_item.ready;
    assign n_hdr        = {i_item.sequence_req, i_item.piggyback};

    // control: stage occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    // payload capture; header CRC is done here to keep the builder short
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item.func         <= i_item.func;
            r_item.data_byte    <= i_item.data_byte;
            r_item.first_byte   <= i_item.first_byte;
            r_item.last_byte    <= i_item.last_byte;
            r_item.sequence_req <= i_item.sequence_req;
            r_item.piggyback    <= i_item.piggyback;
            r_hdr               <= n_hdr;
            r_hdr_crc           <= crc_byte(16'h0000, n_hdr);
        end
    end

    assign o_stage.valid   = r_valid;
    assign o_stage.item    = r_item;
    assign o_stage.hdr     = r_hdr;
    assign o_stage.hdr_crc = r_hdr_crc;

endmodule

@@ hdl/dfe_frame_build.sv @@
// Frame builder: holds the running CRC and open flag, maps one staged
// transaction onto the fixed packet slots. Depends on dfe_pkg.
module dfe_frame_build
    import dfe_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_stage i_stage,
    input  logic   i_pkt_free,
    output logic   o_advance,
    output logic   o_load,
    output t_pkt   o_pkt
);

    logic [15:0] r_crc;
    logic        r_open;

    logic        stray;
    logic        open_en;
    logic        data_en;
    logic        close_en;
    logic [15:0] base_crc;
    logic [15:0] data_crc;
    logic [15:0] close_crc;
    logic [7:0]  hdr;
    logic [7:0]  dat;

    assign hdr = i_stage.hdr;
    assign dat = i_stage.item.data_byte;

    // payload byte with no frame open is dropped
    assign stray    = !i_stage.item.func && !i_stage.item.first_byte && !r_open;
    assign open_en  = i_stage.item.func || i_stage.item.first_byte;
    assign data_en  = !i_stage.item.func;
    assign close_en = i_stage.item.func || i_stage.item.last_byte;

    assign o_advance = i_stage.valid && (stray || i_pkt_free);
    assign o_load    = i_stage.valid && !stray && i_pkt_free;

    // CRC over header (precomputed) then data byte
    assign base_crc  = i_stage.item.first_byte ? i_stage.hdr_crc : r_crc;
    assign data_crc  = crc_byte(base_crc, dat);
    assign close_crc = i_stage.item.func ? i_stage.hdr_crc : data_crc;

    // slot bytes and send mask
    always_comb begin
        o_pkt.bytes            = '0;
        o_pkt.bytes[SLOT_DLE0] = DLE_CODE;
        o_pkt.bytes[SLOT_STX]  = STX_CODE;
        o_pkt.bytes[SLOT_HDR]  = hdr;
        o_pkt.bytes[SLOT_HDR2] = hdr;
        o_pkt.bytes[SLOT_DAT]  = dat;
        o_pkt.bytes[SLOT_DAT2] = dat;
        o_pkt.bytes[SLOT_CHI]  = close_crc[15:8];
        o_pkt.bytes[SLOT_CHI2] = close_crc[15:8];
        o_pkt.bytes[SLOT_CLO]  = close_crc[7:0];
        o_pkt.bytes[SLOT_CLO2] = close_crc[7:0];
        o_pkt.bytes[SLOT_DLE1] = DLE_CODE;
        o_pkt.bytes[SLOT_ETX]  = ETX_CODE;

        o_pkt.mask            = '0;
        o_pkt.mask[SLOT_DLE0] = open_en;
        o_pkt.mask[SLOT_STX]  = open_en;
        o_pkt.mask[SLOT_HDR]  = open_en;
        o_pkt.mask[SLOT_HDR2] = open_en && (hdr == DLE_CODE);
        o_pkt.mask[SLOT_DAT]  = data_en;
        o_pkt.mask[SLOT_DAT2] = data_en && (dat == DLE_CODE);
        o_pkt.mask[SLOT_CHI]  = close_en;
        o_pkt.mask[SLOT_CHI2] = close_en && (close_crc[15:8] == DLE_CODE);
        o_pkt.mask[SLOT_CLO]  = close_en;
        o_pkt.mask[SLOT_CLO2] = close_en && (close_crc[7:0] == DLE_CODE);
        o_pkt.mask[SLOT_DLE1] = close_en;
        o_pkt.mask[SLOT_ETX]  = close_en;
    end

    // frame state: cleared on close, else carries the running CRC
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= '0;
            r_open <= 1'b0;
        end else if (o_load) begin
            if (close_en) begin
                r_crc  <= '0;
                r_open <= 1'b0;
            end else begin
                r_crc  <= data_crc;
                r_open <= 1'b1;
            end
        end
    end

endmodule

@@ hdl/dfe_emit.sv @@
// Result register and byte serializer: sends the masked slots of one
// packet in slot order, one byte per transaction. Depends on dfe_pkg, dfe_out_if.
module dfe_emit
    import dfe_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_pkt      i_pkt,
    output logic      o_free,
    dfe_out_if.source o_out
);

    logic [NSLOT-1:0][7:0] r_bytes;
    logic [NSLOT-1:0]      r_mask;
    logic [SLOT_W-1:0]     sel;
    logic                  last_one;
    logic                  take;

    // lowest pending slot
    always_comb begin
        sel = '0;
        for (int i = NSLOT - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                sel = SLOT_W'(i);
            end
        end
    end

    assign last_one = (r_mask != '0) && ((r_mask & (r_mask - 1'b1)) == '0);
    assign take     = o_out.valid && o_out.ready;
    assign o_free   = (r_mask == '0) || (take && last_one);

    assign o_out.valid      = (r_mask != '0);
    assign o_out.out_byte   = r_bytes[sel];
    assign o_out.run_last   = last_one;
    assign o_out.frame_done = (sel == SLOT_ETX);

    // pending mask: reload on a new packet, else drop the sent slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (i_load) begin
            r_mask <= i_pkt.mask;
        end else if (take) begin
            r_mask[sel] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_pkt.bytes;
        end
    end

endmodule

@@ hdl/dle_frame_encoder_crc16.sv @@
// DLE/STX/ETX byte-stuffed frame encoder with CRC-16 (poly 0x1021, init 0).
// Each input transaction is a payload byte (opening, continuing or closing a
// frame) or a control request that yields a whole frame with no payload. The
// line stream leaves one byte per output transaction; an input transaction
// causes from 1 (plain payload byte) to 12 (single-byte frame with DLE
// stuffing) line bytes; a control frame causes 7 to 10. The serializer sends
// one byte per cycle while the output is ready; a new transaction is accepted
// while the previous packet is still being sent. A payload byte with no frame
// open is dropped from the input register and produces no output.
// Depends on dfe_pkg, dfe_in_if, dfe_out_if and the three dfe_ submodules.
module dle_frame_encoder_crc16
    import dfe_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    dfe_in_if.sink    i_item,
    dfe_out_if.source o_byte
);

    t_stage stage;
    t_pkt   pkt;
    logic   advance;
    logic   load;
    logic   pkt_free;

    // input register and header CRC
    dfe_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .i_advance (advance),
        .o_stage   (stage)
    );

    // frame state and packet build
    dfe_frame_build u_build (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_stage    (stage),
        .i_pkt_free (pkt_free),
        .o_advance  (advance),
        .o_load     (load),
        .o_pkt      (pkt)
    );

    // result register and serializer
    dfe_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_pkt   (pkt),
        .o_free  (pkt_free),
        .o_out   (o_byte)
    );

endmodule
